// File: rtl/core/ppte_pkg.sv
// Shared types, widths, codes and helper functions for the trajectory evaluator.
// No dependencies; every other file in rtl/core except ppte_ram imports this package.
package ppte_pkg;

	localparam int DEF_MAX_SEGMENTS = 16;
	localparam int DEF_POLY_ORDER   = 7;
	localparam int TIME_W           = 24;
	localparam int COEF_W           = 48;
	localparam int OUT_W            = 32;
	localparam int TOT_W            = 28;
	localparam int CNT_W            = 5;
	localparam int AXES             = 3;
	localparam int POWER_SLOTS      = 8;
	localparam int ACC_W            = 63;
	localparam logic [ACC_W-2:0] ACC_LIM = {(ACC_W-1){1'b1}};

	localparam logic [1:0] MODE_LOAD_COEF = 2'd0;
	localparam logic [1:0] MODE_LOAD_DUR  = 2'd1;
	localparam logic [1:0] MODE_EVAL      = 2'd2;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic       ld_coef;
		logic       ld_dur;
		logic       eval_init;
		logic       dur_rd;
		logic [7:0] scan_idx;
		logic       scan_use;
		logic [7:0] use_idx;
		logic       scan_last;
		logic       tau_calc;
		logic       v_clr;
		logic       coef_rd;
		logic [1:0] axis;
		logic [2:0] power;
		logic [1:0] deriv;
		logic       mul0;
		logic       mul1;
		logic       acc;
		logic       sum;
		logic       fin;
	} cmd_t;

	// k! / (k-d)!, valid for k >= d
	function automatic logic [7:0] falling_fn(input logic [2:0] k, input logic [1:0] d);
		logic [7:0] f;
		f = 8'd1;
		for (int j = 0; j < 3; j++) begin
			if (j < int'(d)) begin
				f = 8'(f * 8'(k - 3'(j)));
			end
		end
		return f;
	endfunction

endpackage

// File: rtl/core/piecewise_poly_trajectory_eval_core.sv
// Top level of the piecewise 7th-order 3-axis trajectory evaluator.
// Depends on ppte_pkg, ppte_ctrl, ppte_dp (which holds two ppte_ram tables).
//
//  channel   handshake               payload
//  -------   ---------------------   ------------------------------------------------
//  item in   start & !busy           mode, segment_slot, axis_sel, power_index,
//                                    coef_value, seg_duration, query_time, deriv_order
//  result    done (1-cycle strobe)   value_x/y/z, chosen_segment, local_time,
//                                    total_duration
//  config    cfg_we                  cfg_wdata = segments in use
//
// Load items complete in the accept cycle; busy stays low.
// An evaluate item holds busy through the segment scan and tau, then the Horner terms
// of each axis (address, two multiplies, accumulate, sum, then a finish step per axis)
// on the one shared multiply/accumulate unit, and through the result state.
// With no segments in use the all-zero result is on the ports in the cycle after accept.
// Reset clears the sequencer and the segment count; tables hold garbage until loaded.
// Results cannot be held off: done is high for exactly one cycle per evaluate item.
module piecewise_poly_trajectory_eval_core #(
	parameter int MAX_SEGMENTS = ppte_pkg::DEF_MAX_SEGMENTS,
	parameter int POLY_ORDER   = ppte_pkg::DEF_POLY_ORDER
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          mode,
	input  logic [3:0]                          segment_slot,
	input  logic [1:0]                          axis_sel,
	input  logic [2:0]                          power_index,
	input  logic signed [ppte_pkg::COEF_W-1:0]  coef_value,
	input  logic [ppte_pkg::TIME_W-1:0]         seg_duration,
	input  logic [ppte_pkg::TIME_W-1:0]         query_time,
	input  logic [1:0]                          deriv_order,
	input  logic                                cfg_we,
	input  logic [ppte_pkg::CNT_W-1:0]          cfg_wdata,
	output logic                                done,
	output logic signed [ppte_pkg::OUT_W-1:0]   value_x,
	output logic signed [ppte_pkg::OUT_W-1:0]   value_y,
	output logic signed [ppte_pkg::OUT_W-1:0]   value_z,
	output logic [3:0]                          chosen_segment,
	output logic [ppte_pkg::TIME_W-1:0]         local_time,
	output logic [ppte_pkg::TOT_W-1:0]          total_duration
);
	import ppte_pkg::*;

	cmd_t cmd;

	// sequencer: decodes each item, walks the scan and the Horner steps
	ppte_ctrl #(.MAX_SEGMENTS(MAX_SEGMENTS), .POLY_ORDER(POLY_ORDER)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.mode       (mode),
		.deriv_order(deriv_order),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.busy       (busy),
		.done       (done),
		.cmd        (cmd)
	);

	// tables and arithmetic; result registers hold steady through the done cycle
	ppte_dp #(.MAX_SEGMENTS(MAX_SEGMENTS), .POLY_ORDER(POLY_ORDER)) u_dp (
		.clk           (clk),
		.cmd           (cmd),
		.segment_slot  (segment_slot),
		.axis_sel      (axis_sel),
		.power_index   (power_index),
		.coef_value    (coef_value),
		.seg_duration  (seg_duration),
		.query_time    (query_time),
		.value_x       (value_x),
		.value_y       (value_y),
		.value_z       (value_z),
		.chosen_segment(chosen_segment),
		.local_time    (local_time),
		.total_duration(total_duration)
	);

endmodule

// File: rtl/core/ppte_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ppte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/core/ppte_ctrl.sv
// Sequencer for the trajectory evaluator: load decode, segment scan, Horner steps.
// Depends on ppte_pkg; drives ppte_dp through cmd_t.
module ppte_ctrl #(
	parameter int MAX_SEGMENTS = ppte_pkg::DEF_MAX_SEGMENTS,
	parameter int POLY_ORDER   = ppte_pkg::DEF_POLY_ORDER
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [1:0]                mode,
	input  logic [1:0]                deriv_order,
	input  logic                      cfg_we,
	input  logic [ppte_pkg::CNT_W-1:0] cfg_wdata,
	output logic                      busy,
	output logic                      done,
	output ppte_pkg::cmd_t            cmd
);
	import ppte_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE     = 11'b00000000001,
		S_SCAN     = 11'b00000000010,
		S_SCAN_END = 11'b00000000100,
		S_TAU      = 11'b00000001000,
		S_ADDR     = 11'b00000010000,
		S_MUL0     = 11'b00000100000,
		S_MUL1     = 11'b00001000000,
		S_ACC      = 11'b00010000000,
		S_SUM      = 11'b00100000000,
		S_FIN      = 11'b01000000000,
		S_DONE     = 11'b10000000000
	} state_t;

	state_t state_q, state_d;
	logic [CNT_W-1:0] seg_cnt_q;
	logic [8:0] n_q, n_eff;
	logic [7:0] idx_q;
	logic [1:0] d_q, axis_q;
	logic [2:0] k_q;
	logic use_vld_q, use_last_q;
	logic [7:0] use_idx_q;
	logic accept, scan_last, deriv_gt;

	assign accept    = start && (state_q == S_IDLE);
	assign n_eff     = (9'(seg_cnt_q) > 9'(MAX_SEGMENTS)) ? 9'(MAX_SEGMENTS) : 9'(seg_cnt_q);
	assign scan_last = (9'(idx_q) == n_q - 9'd1);
	assign deriv_gt  = (3'(d_q) > 3'(POLY_ORDER));
	assign busy      = (state_q != S_IDLE);
	assign done      = (state_q == S_DONE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.scan_idx  = idx_q;
		cmd.scan_use  = use_vld_q;
		cmd.use_idx   = use_idx_q;
		cmd.scan_last = use_last_q;
		cmd.axis      = axis_q;
		cmd.power     = k_q;
		cmd.deriv     = d_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (mode)
						MODE_LOAD_COEF: cmd.ld_coef = 1'b1;
						MODE_LOAD_DUR:  cmd.ld_dur = 1'b1;
						MODE_EVAL: begin
							cmd.eval_init = 1'b1;
							state_d = (n_eff == 9'd0) ? S_DONE : S_SCAN;
						end
						default: ;
					endcase
				end
			end
			S_SCAN: begin
				cmd.dur_rd = 1'b1;
				if (scan_last) state_d = S_SCAN_END;
			end
			S_SCAN_END: state_d = S_TAU;
			S_TAU: begin
				cmd.tau_calc = 1'b1;
				cmd.v_clr = 1'b1;
				state_d = deriv_gt ? S_FIN : S_ADDR;
			end
			S_ADDR: begin
				cmd.coef_rd = 1'b1;
				state_d = S_MUL0;
			end
			S_MUL0: begin
				cmd.mul0 = 1'b1;
				state_d = S_MUL1;
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = (k_q == 3'(d_q)) ? S_FIN : S_ADDR;
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				if (axis_q == AXIS_Z) begin
					state_d = S_DONE;
				end else begin
					cmd.v_clr = 1'b1;
					state_d = deriv_gt ? S_FIN : S_ADDR;
				end
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			seg_cnt_q  <= '0;
			n_q        <= '0;
			idx_q      <= '0;
			d_q        <= '0;
			axis_q     <= AXIS_X;
			k_q        <= '0;
			use_vld_q  <= 1'b0;
			use_idx_q  <= '0;
			use_last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) seg_cnt_q <= cfg_wdata;
			use_vld_q <= (state_q == S_SCAN);
			use_idx_q <= idx_q;
			use_last_q <= scan_last;
			if (cmd.eval_init) begin
				n_q   <= n_eff;
				d_q   <= deriv_order;
				idx_q <= '0;
			end
			if (state_q == S_SCAN) idx_q <= idx_q + 8'd1;
			if (state_q == S_TAU) begin
				axis_q <= AXIS_X;
				k_q    <= 3'(POLY_ORDER);
			end
			if (state_q == S_SUM && k_q != 3'(d_q)) k_q <= k_q - 3'd1;
			if (state_q == S_FIN && axis_q != AXIS_Z) begin
				axis_q <= axis_q + 2'd1;
				k_q    <= 3'(POLY_ORDER);
			end
		end
	end

endmodule

// File: rtl/core/ppte_dp.sv
// Datapath: coefficient and duration tables, segment search, shared Horner unit.
// Depends on ppte_pkg and ppte_ram; sequenced by ppte_ctrl through cmd_t.
module ppte_dp #(
	parameter int MAX_SEGMENTS = ppte_pkg::DEF_MAX_SEGMENTS,
	parameter int POLY_ORDER   = ppte_pkg::DEF_POLY_ORDER
) (
	input  logic                                clk,
	input  ppte_pkg::cmd_t                      cmd,
	input  logic [3:0]                          segment_slot,
	input  logic [1:0]                          axis_sel,
	input  logic [2:0]                          power_index,
	input  logic signed [ppte_pkg::COEF_W-1:0]  coef_value,
	input  logic [ppte_pkg::TIME_W-1:0]         seg_duration,
	input  logic [ppte_pkg::TIME_W-1:0]         query_time,
	output logic signed [ppte_pkg::OUT_W-1:0]   value_x,
	output logic signed [ppte_pkg::OUT_W-1:0]   value_y,
	output logic signed [ppte_pkg::OUT_W-1:0]   value_z,
	output logic [3:0]                          chosen_segment,
	output logic [ppte_pkg::TIME_W-1:0]         local_time,
	output logic [ppte_pkg::TOT_W-1:0]          total_duration
);
	import ppte_pkg::*;

	localparam int SEG_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int CA_D  = MAX_SEGMENTS * AXES * POWER_SLOTS;
	localparam int CA_W  = $clog2(CA_D);
	localparam int SUM_W = TIME_W + $clog2(MAX_SEGMENTS + 1);
	localparam logic [SUM_W-1:0] TOT_MAX = SUM_W'({TOT_W{1'b1}});

	function automatic logic [CA_W-1:0] coef_addr(input logic [SEG_W-1:0] s,
			input logic [1:0] a, input logic [2:0] p);
		return CA_W'(CA_W'(s) * CA_W'(AXES * POWER_SLOTS) + CA_W'(a) * CA_W'(POWER_SLOTS)
			+ CA_W'(p));
	endfunction

	// table writes
	logic slot_ok, coef_ok, dur_ok;
	logic [SEG_W-1:0] slot_idx;
	logic [COEF_W-1:0] coef_rdata;
	logic [TIME_W-1:0] dur_rdata;

	assign slot_ok  = (9'(segment_slot) < 9'(MAX_SEGMENTS));
	assign slot_idx = SEG_W'(segment_slot);
	assign coef_ok  = cmd.ld_coef && slot_ok && (axis_sel != 2'd3)
		&& (power_index <= 3'(POLY_ORDER));
	assign dur_ok   = cmd.ld_dur && slot_ok;

	logic [SEG_W-1:0] seg_q;

	ppte_ram #(.WIDTH(COEF_W), .DEPTH(CA_D), .AW(CA_W)) u_coef_ram (
		.clk  (clk),
		.we   (coef_ok),
		.waddr(coef_addr(slot_idx, axis_sel, power_index)),
		.wdata(coef_value),
		.re   (cmd.coef_rd),
		.raddr(coef_addr(seg_q, cmd.axis, cmd.power)),
		.rdata(coef_rdata)
	);

	ppte_ram #(.WIDTH(TIME_W), .DEPTH(MAX_SEGMENTS), .AW(SEG_W)) u_dur_ram (
		.clk  (clk),
		.we   (dur_ok),
		.waddr(slot_idx),
		.wdata(seg_duration),
		.re   (cmd.dur_rd),
		.raddr(cmd.scan_idx[SEG_W-1:0]),
		.rdata(dur_rdata)
	);

	// segment search
	logic [TIME_W-1:0] qt_q, segdur_q, tau_q;
	logic [SUM_W-1:0]  sum_q, base_q, sum_nx, diff;
	logic              found_q, hit;

	assign sum_nx = sum_q + SUM_W'(dur_rdata);
	assign hit    = (SUM_W'(qt_q) <= sum_nx) || cmd.scan_last;
	assign diff   = SUM_W'(qt_q) - base_q;

	// Horner unit
	logic signed [ACC_W-1:0]  v_q;
	logic [ACC_W-2:0]         mag;
	logic [47:0]              pp0_q;
	logic [45:0]              pp1_q;
	logic [39:0]              plo_q;
	logic [48:0]              base0_q;
	logic [ACC_W-2:0]         r_q;
	logic signed [56:0]       term_q;
	logic                     neg_q;
	logic [70:0]              prod;
	logic signed [ACC_W:0]    acc_sum;
	logic signed [ACC_W-1:0]  r_signed;
	logic [46:0]              rnd16;
	logic [OUT_W-1:0]         q16;
	logic [7:0]               fall;

	assign mag      = v_q[ACC_W-1] ? (ACC_W-1)'(-v_q) : v_q[ACC_W-2:0];
	assign fall     = falling_fn(cmd.power, cmd.deriv);
	assign prod     = (71'(pp1_q) << 24) + 71'(base0_q);
	assign r_signed = neg_q ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
	assign acc_sum  = (ACC_W+1)'(r_signed) + (ACC_W+1)'(term_q);
	assign rnd16    = 47'((ACC_W)'(mag) + ACC_W'(16'h8000) >> 16);

	always_comb begin
		if (!v_q[ACC_W-1]) begin
			q16 = (rnd16 > 47'h7FFF_FFFF) ? 32'h7FFF_FFFF : rnd16[OUT_W-1:0];
		end else if (rnd16 > 47'h8000_0000) begin
			q16 = 32'h8000_0000;
		end else begin
			q16 = OUT_W'(-rnd16);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval_init) begin
			qt_q     <= query_time;
			sum_q    <= '0;
			base_q   <= '0;
			found_q  <= 1'b0;
			seg_q    <= '0;
			segdur_q <= '0;
			tau_q    <= '0;
			value_x  <= '0;
			value_y  <= '0;
			value_z  <= '0;
		end else if (cmd.scan_use) begin
			sum_q <= sum_nx;
			if (!found_q && hit) begin
				found_q  <= 1'b1;
				seg_q    <= cmd.use_idx[SEG_W-1:0];
				base_q   <= sum_q;
				segdur_q <= dur_rdata;
			end
		end
		if (cmd.tau_calc) begin
			if (SUM_W'(qt_q) <= base_q) tau_q <= '0;
			else if (diff > SUM_W'(segdur_q)) tau_q <= segdur_q;
			else tau_q <= diff[TIME_W-1:0];
		end
		if (cmd.mul0) begin
			pp0_q  <= mag[39:16] * tau_q;
			plo_q  <= mag[15:0] * tau_q;
			term_q <= $signed(coef_rdata) * $signed({1'b0, fall});
			neg_q  <= v_q[ACC_W-1];
		end
		if (cmd.mul1) begin
			pp1_q   <= mag[61:40] * tau_q;
			base0_q <= 49'(pp0_q) + 49'((41'(plo_q) + 41'h8000) >> 16);
		end
		if (cmd.acc) begin
			r_q <= (prod > 71'(ACC_LIM)) ? ACC_LIM : prod[ACC_W-2:0];
		end
		if (cmd.sum) begin
			if (acc_sum > $signed((ACC_W+1)'(ACC_LIM))) v_q <= $signed({1'b0, ACC_LIM});
			else if (acc_sum < -$signed((ACC_W+1)'(ACC_LIM))) v_q <= -$signed({1'b0, ACC_LIM});
			else v_q <= acc_sum[ACC_W-1:0];
		end
		if (cmd.fin) begin
			case (cmd.axis)
				AXIS_X:  value_x <= q16;
				AXIS_Y:  value_y <= q16;
				default: value_z <= q16;
			endcase
		end
		if (cmd.v_clr) v_q <= '0;
	end

	assign chosen_segment = 4'(seg_q);
	assign local_time     = tau_q;
	assign total_duration = (sum_q > TOT_MAX) ? {TOT_W{1'b1}} : sum_q[TOT_W-1:0];

endmodule
